### rtl/tether_spring_damper_force_assert.svh
`ifndef TETHER_SPRING_DAMPER_FORCE_ASSERT_SVH
`define TETHER_SPRING_DAMPER_FORCE_ASSERT_SVH

// Same-cycle implication on clk, off during rst.
`define TSDF_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication on clk, off during rst.
`define TSDF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/tsdf_pkg.sv
`default_nettype none

package tsdf_pkg;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 31;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MODE          = 3'd0,
    CFG_STIFFNESS     = 3'd1,
    CFG_REST_LENGTH   = 3'd2,
    CFG_DAMPING       = 3'd3,
    CFG_FIRST_WEIGHT  = 3'd4,
    CFG_SECOND_WEIGHT = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] MODE_BARRIER = 2'd0;
  localparam logic [1:0] MODE_SPRING  = 2'd1;
  localparam logic [1:0] MODE_ROPE    = 2'd2;

  localparam logic [1:0]  MODE_RST        = MODE_SPRING;
  localparam logic [15:0] STIFFNESS_RST   = 16'd66;
  localparam logic [30:0] REST_LENGTH_RST = 31'd1966080;
  localparam logic [30:0] DAMPING_RST     = 31'd145072;
  localparam logic [16:0] WEIGHT_RST      = 17'd32768;

  localparam int DMW = 62;
  localparam logic [DMW-1:0] MAG_CAP = '1;

endpackage

`default_nettype wire

### rtl/tsdf_mul.sv
`default_nettype none

module tsdf_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int BL = BW / 2;
  localparam int BH = BW - BL;

  logic [AW+BL-1:0] pl;
  logic [AW+BH-1:0] ph;

  always_ff @(posedge clk) begin
    if (en) begin
      pl <= (AW+BL)'(a) * (AW+BL)'(b[BL-1:0]);
      ph <= (AW+BH)'(a) * (AW+BH)'(b[BW-1:BL]);
      p  <= (AW+BW)'(pl) + ((AW+BW)'(ph) << BL);
    end
  end

endmodule

`default_nettype wire

### rtl/tether_spring_damper_force.sv
// Channel  Dir  Payload
// s_*      in   first_x, first_y, second_x, second_y, first/second velocities
// m_*      out  force_first_x/y, force_second_x/y in tdata, engaged in tuser
// cfg_*    in   register write: index, data
//
// One request accepted per cycle while no stall holds the pipeline; the square root
// and the dividers each resolve one bit per stage.
// rst is synchronous; it clears the stage valid bits and loads register defaults.
// A stall at m_tready holds every stage; s_tready drops with it.
`default_nettype none
`include "tether_spring_damper_force_assert.svh"

module tether_spring_damper_force
  import tsdf_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // first_x, first_y, second_x, second_y, first_vel_x, first_vel_y,
  // second_vel_x, second_vel_y
  input  logic [8*COORD_WIDTH-1:0]            s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // force_first_x, force_first_y, force_second_x, force_second_y, zero fill
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
  // engaged
  output logic                                m_tuser,
  input  logic                                cfg_wr_en,
  input  logic [CFG_IW-1:0]                   cfg_index,
  input  logic [CFG_DW-1:0]                   cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int NW   = 2 * DW;
  localparam int MW   = (DW > 31) ? DW : 31;
  localparam int SUMW = ((MW > 62) ? MW : 62) + 2;
  localparam int SAW  = SUMW - 1;
  localparam int PWD  = 31 + CW;
  localparam int RW   = PWD + 1 - FRAC_BITS;
  localparam int EW   = (RW > 63) ? RW : 63;
  localparam int OW   = ((4*CW+7)/8)*8;

  localparam int S_N   = 3;
  localparam int S_SQE = S_N + DW;
  localparam int S_DIF = S_SQE + 1;
  localparam int S_MAG = S_DIF + 3;
  localparam int S_DV0 = S_MAG + 3;
  localparam int S_DVE = S_DV0 + MW;
  localparam int S_SPR = S_DVE + 1;
  localparam int S_SUM = S_SPR + 1;
  localparam int S_FRC = S_SUM + 3;
  localparam int LAST  = S_FRC + 1;
  localparam int NST   = LAST + 1;

  typedef struct packed {
    logic [DW-1:0]           adx;
    logic [DW-1:0]           ady;
    logic                    nx;
    logic                    ny;
    logic [3:0][CW-1:0]      vmag;
    logic [3:0]              vpos;
    logic [3:0][DMW-1:0]     dmag;
    logic [3:0]              dneg;
    logic [NW-1:0]           sqn;
    logic [DW:0]             sqr;
    logic [DW-1:0]           root;
    logic                    act;
    logic                    mneg;
    logic                    dzero;
    logic [MW-1:0]           adiff;
    logic [MW-1:0]           magm;
    logic [1:0][MW-1:0]      nlo;
    logic [1:0][DW-1:0]      drem;
    logic [1:0][MW-1:0]      q;
    logic [1:0][MW-1:0]      smag;
    logic [1:0]              sneg;
    logic [3:0][SAW-1:0]     sabs;
    logic [3:0]              sumneg;
    logic [3:0][CW-1:0]      frc;
    logic                    engaged;
  } stg_t;

  logic [1:0]  mode;
  logic [15:0] stiffness;
  logic [30:0] rest_length;
  logic [30:0] damping;
  logic [16:0] first_weight;
  logic [16:0] second_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_RST;
      stiffness     <= STIFFNESS_RST;
      rest_length   <= REST_LENGTH_RST;
      damping       <= DAMPING_RST;
      first_weight  <= WEIGHT_RST;
      second_weight <= WEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MODE:          mode          <= cfg_data[1:0];
        CFG_STIFFNESS:     stiffness     <= cfg_data[15:0];
        CFG_REST_LENGTH:   rest_length   <= cfg_data[30:0];
        CFG_DAMPING:       damping       <= cfg_data[30:0];
        CFG_FIRST_WEIGHT:  first_weight  <= cfg_data[16:0];
        CFG_SECOND_WEIGHT: second_weight <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic             adv;
  logic [NST-1:0]   vld;
  stg_t             st  [NST];
  stg_t             nxt [NST];

  logic [NW-1:0]          sqx, sqy;
  logic [3:0][PWD-1:0]    dprod;
  logic [MW+15:0]         kprod;
  logic [1:0][MW+DW-1:0]  nprod;
  logic [3:0][SAW+16:0]   wprod;

  assign adv      = !vld[LAST] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAST];
  assign m_tdata  = OW'(st[LAST].frc);
  assign m_tuser  = st[LAST].engaged;

  tsdf_mul #(.AW(DW), .BW(DW)) u_sqx (
    .clk(clk), .en(adv), .a(st[0].adx), .b(st[0].adx), .p(sqx));
  tsdf_mul #(.AW(DW), .BW(DW)) u_sqy (
    .clk(clk), .en(adv), .a(st[0].ady), .b(st[0].ady), .p(sqy));
  tsdf_mul #(.AW(16), .BW(MW)) u_kmul (
    .clk(clk), .en(adv), .a(stiffness), .b(st[S_DIF].adiff), .p(kprod));
  tsdf_mul #(.AW(DW), .BW(MW)) u_nx (
    .clk(clk), .en(adv), .a(st[S_MAG].adx), .b(st[S_MAG].magm), .p(nprod[0]));
  tsdf_mul #(.AW(DW), .BW(MW)) u_ny (
    .clk(clk), .en(adv), .a(st[S_MAG].ady), .b(st[S_MAG].magm), .p(nprod[1]));

  for (genvar e = 0; e < 4; e++) begin : g_end
    tsdf_mul #(.AW(31), .BW(CW)) u_dmul (
      .clk(clk), .en(adv), .a(damping), .b(st[0].vmag[e]), .p(dprod[e]));
    tsdf_mul #(.AW(17), .BW(SAW)) u_wmul (
      .clk(clk), .en(adv), .a((e < 2) ? first_weight : second_weight),
      .b(st[S_SUM].sabs[e]), .p(wprod[e]));
  end

  always_comb begin
    logic signed [CW-1:0] px, py, qx, qy, vel;
    logic signed [CW:0]   dx, dy;
    logic [PWD:0]         draw;
    logic [EW-1:0]        dext;
    logic [DW+2:0]        cand, trial;
    logic [MW:0]          diff;
    logic [MW+15:0]       kr;
    logic [DW:0]          dc, dd;
    logic                 up, sg;
    logic [SUMW-1:0]      ss, ds, sm;
    logic [SAW+16:0]      wr;
    logic [SAW:0]         m;

    for (int i = 1; i < NST; i++) nxt[i] = st[i-1];

    nxt[0] = '0;
    px = s_tdata[0*CW +: CW];
    py = s_tdata[1*CW +: CW];
    qx = s_tdata[2*CW +: CW];
    qy = s_tdata[3*CW +: CW];
    dx = (CW+1)'(qx) - (CW+1)'(px);
    dy = (CW+1)'(qy) - (CW+1)'(py);
    nxt[0].nx  = dx[CW];
    nxt[0].ny  = dy[CW];
    nxt[0].adx = dx[CW] ? DW'(-dx) : DW'(dx);
    nxt[0].ady = dy[CW] ? DW'(-dy) : DW'(dy);
    for (int e = 0; e < 4; e++) begin
      vel = s_tdata[(4+e)*CW +: CW];
      nxt[0].vmag[e] = vel[CW-1] ? CW'(-vel) : CW'(vel);
      nxt[0].vpos[e] = !vel[CW-1] && (vel != '0);
    end

    nxt[S_N].sqn  = sqx + sqy;
    nxt[S_N].sqr  = '0;
    nxt[S_N].root = '0;
    for (int e = 0; e < 4; e++) begin
      draw = (PWD+1)'(dprod[e]) + ((PWD+1)'(1) << (FRAC_BITS-1));
      dext = EW'(draw[PWD:FRAC_BITS]);
      nxt[S_N].dmag[e] = (dext > EW'(MAG_CAP)) ? MAG_CAP : dext[DMW-1:0];
      nxt[S_N].dneg[e] = st[S_N-1].vpos[e];
    end

    for (int j = 0; j < DW; j++) begin
      cand  = {st[S_N+j].sqr, st[S_N+j].sqn[NW-1:NW-2]};
      trial = {1'b0, st[S_N+j].root, 2'b01};
      nxt[S_N+j+1].sqn = st[S_N+j].sqn << 2;
      if (cand >= trial) begin
        nxt[S_N+j+1].sqr  = (DW+1)'(cand - trial);
        nxt[S_N+j+1].root = {st[S_N+j].root[DW-2:0], 1'b1};
      end else begin
        nxt[S_N+j+1].sqr  = cand[DW:0];
        nxt[S_N+j+1].root = {st[S_N+j].root[DW-2:0], 1'b0};
      end
    end

    diff = (MW+1)'(st[S_SQE].root) - (MW+1)'(rest_length);
    nxt[S_DIF].mneg  = diff[MW];
    nxt[S_DIF].adiff = diff[MW] ? MW'(-diff) : diff[MW-1:0];
    nxt[S_DIF].dzero = (st[S_SQE].root == '0);
    case (mode)
      MODE_BARRIER: nxt[S_DIF].act = diff[MW];
      MODE_SPRING:  nxt[S_DIF].act = (diff != '0);
      MODE_ROPE:    nxt[S_DIF].act = !diff[MW] && (diff != '0);
      default:      nxt[S_DIF].act = 1'b0;
    endcase

    kr = kprod + (MW+16)'(32768);
    nxt[S_MAG].magm = kr[MW+15:16];

    for (int k = 0; k < 2; k++) begin
      nxt[S_DV0].drem[k] = nprod[k][MW+DW-1:MW];
      nxt[S_DV0].nlo[k]  = nprod[k][MW-1:0];
      nxt[S_DV0].q[k]    = '0;
    end

    for (int j = 0; j < MW; j++) begin
      for (int k = 0; k < 2; k++) begin
        dc = {st[S_DV0+j].drem[k], st[S_DV0+j].nlo[k][MW-1]};
        dd = {1'b0, st[S_DV0+j].root};
        nxt[S_DV0+j+1].nlo[k] = st[S_DV0+j].nlo[k] << 1;
        if (dc >= dd) begin
          nxt[S_DV0+j+1].drem[k] = DW'(dc - dd);
          nxt[S_DV0+j+1].q[k]    = {st[S_DV0+j].q[k][MW-2:0], 1'b1};
        end else begin
          nxt[S_DV0+j+1].drem[k] = dc[DW-1:0];
          nxt[S_DV0+j+1].q[k]    = {st[S_DV0+j].q[k][MW-2:0], 1'b0};
        end
      end
    end

    for (int k = 0; k < 2; k++) begin
      up = ({st[S_DVE].drem[k], 1'b0} >= {1'b0, st[S_DVE].root});
      nxt[S_SPR].smag[k] = st[S_DVE].q[k] + MW'(up);
    end
    nxt[S_SPR].sneg[0] = st[S_DVE].mneg != st[S_DVE].nx;
    nxt[S_SPR].sneg[1] = st[S_DVE].mneg != st[S_DVE].ny;
    if (st[S_DVE].dzero) begin
      nxt[S_SPR].smag[0] = st[S_DVE].magm;
      nxt[S_SPR].smag[1] = '0;
      nxt[S_SPR].sneg[0] = !st[S_DVE].mneg;
    end

    for (int e = 0; e < 4; e++) begin
      sg = st[S_SPR].sneg[e % 2] ^ (e >= 2);
      ss = sg ? SUMW'(-SUMW'(st[S_SPR].smag[e % 2])) : SUMW'(st[S_SPR].smag[e % 2]);
      ds = st[S_SPR].dneg[e] ? SUMW'(-SUMW'(st[S_SPR].dmag[e]))
                             : SUMW'(st[S_SPR].dmag[e]);
      sm = ss + ds;
      nxt[S_SUM].sumneg[e] = sm[SUMW-1];
      nxt[S_SUM].sabs[e]   = sm[SUMW-1] ? SAW'(-sm) : sm[SAW-1:0];
    end

    for (int e = 0; e < 4; e++) begin
      wr = wprod[e] + (SAW+17)'(32768);
      m  = wr[SAW+16:16];
      if (!st[S_FRC-1].act) begin
        nxt[S_FRC].frc[e] = '0;
      end else if (m[SAW:CW-1] != '0) begin
        nxt[S_FRC].frc[e] = st[S_FRC-1].sumneg[e] ? {1'b1, {(CW-1){1'b0}}}
                                                  : {1'b0, {(CW-1){1'b1}}};
      end else begin
        nxt[S_FRC].frc[e] = st[S_FRC-1].sumneg[e] ? CW'(-m[CW-1:0]) : m[CW-1:0];
      end
    end

    nxt[LAST].engaged = st[S_FRC].act && (st[S_FRC].frc != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) st[i] <= nxt[i];
    end
  end

  `TSDF_ASSERT_NOW(a_inactive_zero, m_tvalid && !st[LAST].act,
    m_tdata == '0 && m_tuser == 1'b0, "inactive result not zero")
  `TSDF_ASSERT_NOW(a_engaged_match, m_tvalid,
    m_tuser == (m_tdata != '0), "engaged disagrees with forces")
  `TSDF_ASSERT_NEXT(a_stall_holds, vld[LAST] && !m_tready && !rst,
    vld[LAST] && $stable(st[LAST].engaged), "stalled result lost")

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import tsdf_pkg::*;

  localparam logic [1:0] MODE_OFF = 2'd3;
  localparam logic [63:0] CAP = {2'b00, {62{1'b1}}};
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [31:0] vy2, vx2, vy1, vx1, y2, x2, y1, x1;
  } tether_req_t;

  typedef struct packed {
    logic signed [31:0] f2y, f2x, f1y, f1x;
  } force_set_t;

  typedef struct {
    force_set_t f;
    logic engaged;
  } force_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [255:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic m_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = CFG_MODE;
  logic [CFG_DW-1:0] cfg_data = '0;

  tether_spring_damper_force dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [1:0] reg_mode = MODE_RST;
  logic [15:0] reg_k = STIFFNESS_RST;
  logic [30:0] reg_rest = REST_LENGTH_RST;
  logic [30:0] reg_damp = DAMPING_RST;
  logic [16:0] reg_w1 = WEIGHT_RST;
  logic [16:0] reg_w2 = WEIGHT_RST;

  tether_req_t pending_reqs[$];
  force_result_t expected_forces[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_engaged = 0;

  function automatic logic [63:0] round_shift(logic [127:0] a, logic [127:0] b, int sh);
    logic [127:0] p;
    p = (a * b + (128'd1 << (sh - 1))) >> sh;
    return p > CAP ? CAP : p[63:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] round_div(logic [127:0] n, logic [127:0] d);
    logic [127:0] q, rem;
    q = n / d;
    rem = n - q * d;
    if (rem >= d - rem) q = q + 1;
    return q > CAP ? CAP : q[63:0];
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] end_force(longint spring, longint vel, logic [16:0] w);
    longint damp, total;
    logic [63:0] m;
    damp = longint'(round_shift(reg_damp, mag(vel), 16));
    if (vel > 0) damp = -damp;
    total = spring + damp;
    m = round_shift(mag(total), w, 16);
    if (total < 0) return m >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-longint'(m));
    return m >= 64'h8000_0000 ? 32'h7fff_ffff : m[31:0];
  endfunction

  function automatic force_result_t tether_forces(tether_req_t q);
    force_result_t r;
    longint dx, dy, diff, sx, sy;
    logic [63:0] d, magm;
    logic act, mneg;
    dx = longint'(q.x2) - longint'(q.x1);
    dy = longint'(q.y2) - longint'(q.y1);
    d = isqrt(128'(mag(dx)) * 128'(mag(dx)) + 128'(mag(dy)) * 128'(mag(dy)));
    diff = longint'(d) - longint'(reg_rest);
    r.f = '0;
    r.engaged = 1'b0;
    case (reg_mode)
      MODE_BARRIER: act = diff < 0;
      MODE_SPRING:  act = diff != 0;
      MODE_ROPE:    act = diff > 0;
      default:      act = 1'b0;
    endcase
    if (!act) return r;
    magm = round_shift(mag(diff), reg_k, 16);
    mneg = diff < 0;
    if (d == 0) begin
      sx = mneg ? longint'(magm) : -longint'(magm);
      sy = 0;
    end else begin
      sx = longint'(round_div(128'(magm) * 128'(mag(dx)), d));
      sy = longint'(round_div(128'(magm) * 128'(mag(dy)), d));
      if (mneg != (dx < 0)) sx = -sx;
      if (mneg != (dy < 0)) sy = -sy;
    end
    r.f.f1x = end_force(sx, q.vx1, reg_w1);
    r.f.f1y = end_force(sy, q.vy1, reg_w1);
    r.f.f2x = end_force(-sx, q.vx2, reg_w2);
    r.f.f2y = end_force(-sy, q.vy2, reg_w2);
    r.engaged = r.f != '0;
    return r;
  endfunction

  // sender: bursts and gaps
  tether_req_t cur_req;
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_forces.push_back(tether_forces(cur_req));
        n_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          s_tdata <= cur_req;
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      s_tvalid <= nv;
    end
  end

  // receiver: stall style is redrawn at random from four styles
  int stall_style = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= $urandom_range(0, 3) == 0;
      default: m_tready <= (stall_tick % 8) < 5;
    endcase
  end

  always @(posedge clk) begin
    force_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_recv++;
      if (m_tuser) n_engaged++;
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected result %h engaged %b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        e = expected_forces.pop_front();
        if (m_tdata[31:0] !== e.f.f1x) begin
          $display("%0t: force_first_x exp %h got %h", $time, e.f.f1x, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] !== e.f.f1y) begin
          $display("%0t: force_first_y exp %h got %h", $time, e.f.f1y, m_tdata[63:32]);
          errors++;
        end
        if (m_tdata[95:64] !== e.f.f2x) begin
          $display("%0t: force_second_x exp %h got %h", $time, e.f.f2x, m_tdata[95:64]);
          errors++;
        end
        if (m_tdata[127:96] !== e.f.f2y) begin
          $display("%0t: force_second_y exp %h got %h", $time, e.f.f2y, m_tdata[127:96]);
          errors++;
        end
        if (m_tuser !== e.engaged) begin
          $display("%0t: engaged exp %b got %b", $time, e.engaged, m_tuser);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [30:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_MODE:          reg_mode = v[1:0];
      CFG_STIFFNESS:     reg_k = v[15:0];
      CFG_REST_LENGTH:   reg_rest = v;
      CFG_DAMPING:       reg_damp = v;
      CFG_FIRST_WEIGHT:  reg_w1 = v[16:0];
      CFG_SECOND_WEIGHT: reg_w2 = v[16:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [1:0] m, logic [15:0] k, logic [30:0] rl,
                           logic [30:0] dmp, logic [16:0] w1, logic [16:0] w2);
    write_reg(CFG_MODE, 31'(m));
    write_reg(CFG_STIFFNESS, 31'(k));
    write_reg(CFG_REST_LENGTH, rl);
    write_reg(CFG_DAMPING, dmp);
    write_reg(CFG_FIRST_WEIGHT, 31'(w1));
    write_reg(CFG_SECOND_WEIGHT, 31'(w2));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || s_tvalid || expected_forces.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] jitter(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic tether_req_t random_req();
    tether_req_t q;
    longint len, ax, ay;
    int kind;
    kind = $urandom_range(0, 9);
    q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (kind < 2) return q;
    if ($urandom_range(0, 1)) begin
      q.vx1 = jitter(1 << 18); q.vy1 = jitter(1 << 18);
      q.vx2 = jitter(1 << 18); q.vy2 = jitter(1 << 18);
    end
    q.x1 = jitter(1 << 24);
    q.y1 = jitter(1 << 24);
    if (kind == 2) begin
      q.x2 = q.x1;
      q.y2 = q.y1;
      return q;
    end
    len = longint'(reg_rest) + longint'(jitter(($urandom_range(0, 1)) ? 4 : (1 << 18)));
    if (len < 0) len = -len;
    ax = $urandom_range(0, 3) == 0 ? len : longint'($urandom_range(0, 32'(len)));
    ay = longint'(isqrt(128'(len * len - ax * ax)));
    if ($urandom_range(0, 1)) ax = -ax;
    if ($urandom_range(0, 1)) ay = -ay;
    q.x2 = 32'(longint'(q.x1) + ax);
    q.y2 = 32'(longint'(q.y1) + ay);
    return q;
  endfunction

  function automatic tether_req_t pair(logic signed [31:0] x1, logic signed [31:0] y1,
                                       logic signed [31:0] x2, logic signed [31:0] y2,
                                       logic signed [31:0] v);
    tether_req_t q;
    q.x1 = x1; q.y1 = y1; q.x2 = x2; q.y2 = y2;
    q.vx1 = v; q.vy1 = -v; q.vx2 = ~v; q.vy2 = v;
    return q;
  endfunction

  task automatic random_phase(int n);
    repeat (n) pending_reqs.push_back(random_req());
    wait_idle();
  endtask

  localparam logic signed [31:0] SMIN = 32'h8000_0000;
  localparam logic signed [31:0] SMAX = 32'h7fff_ffff;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // defaults, directed corner cases
    pending_reqs.push_back(pair(0, 0, 0, 0, 0));
    pending_reqs.push_back(pair(100, 200, 100, 200, 32'sh10000));
    pending_reqs.push_back(pair(0, 0, 1966080, 0, 0));
    pending_reqs.push_back(pair(0, 0, 0, -1966080, 0));
    pending_reqs.push_back(pair(0, 0, 1966081, 0, 0));
    pending_reqs.push_back(pair(0, 0, 1966079, 0, 0));
    pending_reqs.push_back(pair(SMIN, SMIN, SMAX, SMAX, SMAX));
    pending_reqs.push_back(pair(SMAX, SMAX, SMIN, SMIN, SMIN));
    pending_reqs.push_back(pair(SMAX, 0, SMIN, 0, -1));
    pending_reqs.push_back(pair(0, SMIN, 0, SMAX, 1));
    pending_reqs.push_back(pair(-1, -1, -1, -1, SMIN));
    pending_reqs.push_back(pair(1000, -3000, 1500000, 1200000, 32'sh7000));
    pending_reqs.push_back(pair(-5, 7, 1179648, 1572864, -32'sh3000));
    wait_idle();
    random_phase(60);

    write_all(MODE_BARRIER, 16'd1000, 31'd655360, 31'd50000, 17'd65536, 17'd0);
    pending_reqs.push_back(pair(0, 0, 0, 0, 32'sh100));
    pending_reqs.push_back(pair(0, 0, 655360, 0, 0));
    pending_reqs.push_back(pair(0, 0, 655361, 0, 0));
    pending_reqs.push_back(pair(0, 0, 0, 655359, 0));
    wait_idle();
    random_phase(70);

    write_all(MODE_ROPE, 16'd65535, 31'd100000, 31'd0, 17'd131071, 17'd65536);
    random_phase(70);

    write_all(MODE_OFF, 16'd40000, 31'd200000, 31'd300000, 17'd32768, 17'd32768);
    random_phase(40);

    write_all(MODE_SPRING, 16'd0, 31'd0, 31'h7fff_ffff, 17'd0, 17'd131071);
    random_phase(70);

    write_all(MODE_SPRING, 16'd65535, 31'h7fff_ffff, 31'd0, 17'd65536, 17'd65536);
    pending_reqs.push_back(pair(0, 0, 0, 0, 0));
    pending_reqs.push_back(pair(SMIN, 0, SMAX, 0, 0));
    wait_idle();
    random_phase(70);

    write_all(MODE_BARRIER, 16'd65535, 31'h7fff_ffff, 31'h7fff_ffff, 17'd131071, 17'd131071);
    random_phase(70);

    write_all(MODE_SPRING, 16'd66, 31'd1966080, 31'd145072, 17'd43690, 17'd21846);
    random_phase(90);

    write_all(MODE_ROPE, 16'd5000, 31'd4000000, 31'd900000, 17'd50000, 17'd15536);
    random_phase(90);

    write_all(MODE_SPRING, 16'd12345, 31'd80000000, 31'd1234567, 17'd65536, 17'd1);
    random_phase(70);

    $display("covered %0d tether requests over ten register settings, all modes",
             n_sent);
    $display("%0d results checked, %0d with the tether engaged", n_recv, n_engaged);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
